@@ sv/mmpb_pkg.sv @@
// ----------------------------------------------------------------------------
// mmpb_pkg: shared types and constants for the multi-mode controller
// Fixed-point widths, mode codes and register indexes used by the channel
// interfaces and the controller datapath.
// ----------------------------------------------------------------------------
package mmpb_pkg;

   // Q7.8 samples and drive, Q8.8 error, Q5.12 gains
   localparam int SAMPLE_W    = 16;
   localparam int ERROR_W     = 17;
   localparam int GAIN_W      = 18;
   localparam int LEVEL_W     = 15;
   localparam int DRIVE_ACC_W = 24;
   localparam int FRAC_SHIFT  = 12;

   localparam int PROD_W   = GAIN_W + ERROR_W;       // one gain * error product
   localparam int ACC_W    = PROD_W + 2;             // sum of three products
   localparam int PROP_Q_W = PROD_W - FRAC_SHIFT;    // proportional product, Q.8
   localparam int ACC_Q_W  = ACC_W - FRAC_SHIFT;     // PID increment, Q.8
   localparam int SUM_W    = ACC_Q_W + 1;            // stored drive plus increment

   localparam int SAMPLE_MAX    = 32767;
   localparam int SAMPLE_MIN    = -32768;
   localparam int DRIVE_ACC_MAX = 8388607;
   localparam int DRIVE_ACC_MIN = -8388608;

   localparam int MODE_W      = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 18;

   typedef logic signed [SAMPLE_W-1:0]    sample_type;
   typedef logic signed [ERROR_W-1:0]     error_type;
   typedef logic signed [GAIN_W-1:0]      gain_type;
   typedef logic [LEVEL_W-1:0]            level_type;
   typedef logic signed [DRIVE_ACC_W-1:0] drive_acc_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_PASS      = 3'd0,
      MODE_BANG_UNI  = 3'd1,
      MODE_BANG_BI   = 3'd2,
      MODE_BANG_HYST = 3'd3,
      MODE_PROP      = 3'd4,
      MODE_PID       = 3'd5
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CONTROL_MODE         = 3'd0,
      CSR_GAIN_CURRENT         = 3'd1,
      CSR_GAIN_PREVIOUS        = 3'd2,
      CSR_GAIN_BEFORE_PREVIOUS = 3'd3,
      CSR_PROPORTIONAL_GAIN    = 3'd4,
      CSR_DRIVE_LIMIT          = 3'd5,
      CSR_HALF_HYSTERESIS      = 3'd6,
      CSR_BANG_LEVEL           = 3'd7
   } csr_index_type;

endpackage

@@ sv/mmpb_if.sv @@
// ----------------------------------------------------------------------------
// mmpb channel interfaces
// Sample request, drive response and register write channels, each a
// valid/ready handshake with a source and a sink side.
// ----------------------------------------------------------------------------
interface mmpb_req_if import mmpb_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type reference;
   sample_type measured;

   modport source (output valid, output reference, output measured, input ready);
   modport sink (input valid, input reference, input measured, output ready);
endinterface

interface mmpb_rsp_if import mmpb_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type drive;
   logic       clipped;

   modport source (output valid, output drive, output clipped, input ready);
   modport sink (input valid, input drive, input clipped, output ready);
endinterface

interface mmpb_csr_if import mmpb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/multi_mode_pid_bang_controller.sv @@
// ----------------------------------------------------------------------------
// multi_mode_pid_bang_controller: six-mode sampled loop controller
// Pass-through, bang-bang (unipolar, bipolar, hysteresis), proportional and
// incremental PID control of one Q7.8 drive per reference/measured sample.
// ----------------------------------------------------------------------------
// The block takes one sample per clock and returns one drive beat per sample,
// in order, through an input register and then a result register; with the
// response side ready it sustains one sample per cycle.
// The whole control law, including the three Q5.12 x Q8.8 multiplies and
// their sum in PID mode, is evaluated in the single pass between those two
// registers; as each sample enters the result register the stored drive (PID,
// hysteresis) and error history (PID) update, so a following sample sees them at once.
// Registers are written through the csr channel, which is always ready, and
// should only be changed while no sample is in flight.
module multi_mode_pid_bang_controller import mmpb_pkg::*; (
   input logic       clock,
   input logic       reset,
   mmpb_req_if.sink   req_bus,
   mmpb_rsp_if.source rsp_bus,
   mmpb_csr_if.sink   csr_bus
);

   // configuration
   logic [MODE_W-1:0] control_mode_ff;
   gain_type          gain_current_ff;
   gain_type          gain_previous_ff;
   gain_type          gain_before_previous_ff;
   gain_type          proportional_gain_ff;
   level_type         drive_limit_ff;
   level_type         half_hysteresis_ff;
   level_type         bang_level_ff;

   // controller state
   error_type     error_last_ff, error_last_in;
   error_type     error_before_last_ff, error_before_last_in;
   drive_acc_type drive_last_ff, drive_last_in;

   // input and result registers
   logic       in_valid_ff, in_valid_in;
   sample_type reference_ff;
   sample_type measured_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type drive_ff, drive_in;
   logic       clipped_ff, clipped_in;

   logic req_fire;
   logic advance;

   // datapath
   error_type                  err;
   logic signed [GAIN_W-1:0]   err_wide;
   logic signed [GAIN_W-1:0]   half_pos;
   sample_type                 bang_pos;
   drive_acc_type              hyst_drive;
   logic signed [PROD_W-1:0]   prop_prod;
   logic signed [PROP_Q_W-1:0] prop_q;
   logic signed [PROD_W-1:0]   pid_prod0, pid_prod1, pid_prod2;
   logic signed [ACC_W-1:0]    pid_acc;
   logic signed [ACC_Q_W-1:0]  pid_inc;
   logic signed [SUM_W-1:0]    pid_sum;
   drive_acc_type              pid_store;
   drive_acc_type              limit_pos;

   // --------------------------------------------------------------------
   // Register writes
   // --------------------------------------------------------------------
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         control_mode_ff         <= MODE_PASS;
         gain_current_ff         <= 18'sd4096;
         gain_previous_ff        <= -18'sd4096;
         gain_before_previous_ff <= 18'sd0;
         proportional_gain_ff    <= 18'sd4096;
         drive_limit_ff          <= 15'd2560;
         half_hysteresis_ff      <= 15'd6;
         bang_level_ff           <= 15'd51;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_index_type'(csr_bus.index))
            CSR_CONTROL_MODE:         control_mode_ff         <= csr_bus.data[MODE_W-1:0];
            CSR_GAIN_CURRENT:         gain_current_ff         <= signed'(csr_bus.data);
            CSR_GAIN_PREVIOUS:        gain_previous_ff        <= signed'(csr_bus.data);
            CSR_GAIN_BEFORE_PREVIOUS: gain_before_previous_ff <= signed'(csr_bus.data);
            CSR_PROPORTIONAL_GAIN:    proportional_gain_ff    <= signed'(csr_bus.data);
            CSR_DRIVE_LIMIT:          drive_limit_ff          <= csr_bus.data[LEVEL_W-1:0];
            CSR_HALF_HYSTERESIS:      half_hysteresis_ff      <= csr_bus.data[LEVEL_W-1:0];
            CSR_BANG_LEVEL:           bang_level_ff           <= csr_bus.data[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------------------
   // Handshake: the input register drains into the result register
   // whenever the result slot is empty or being taken.
   // --------------------------------------------------------------------
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // --------------------------------------------------------------------
   // Control law
   // --------------------------------------------------------------------
   always_comb begin
      err      = ERROR_W'(reference_ff) - ERROR_W'(measured_ff);
      err_wide = GAIN_W'(err);
      half_pos = signed'({3'b000, half_hysteresis_ff});
      bang_pos = signed'({1'b0, bang_level_ff});

      // hysteresis: move to a rail only outside the band, else hold
      hyst_drive = drive_last_ff;
      if (err_wide > half_pos) begin
         hyst_drive = DRIVE_ACC_W'(bang_pos);
      end else if (err_wide < -half_pos) begin
         hyst_drive = DRIVE_ACC_W'(-bang_pos);
      end

      prop_prod = PROD_W'(proportional_gain_ff) * PROD_W'(err);
      prop_q    = signed'(prop_prod[PROD_W-1:FRAC_SHIFT]);

      pid_prod0 = PROD_W'(gain_current_ff) * PROD_W'(err);
      pid_prod1 = PROD_W'(gain_previous_ff) * PROD_W'(error_last_ff);
      pid_prod2 = PROD_W'(gain_before_previous_ff) * PROD_W'(error_before_last_ff);
      pid_acc   = ACC_W'(pid_prod0) + ACC_W'(pid_prod1) + ACC_W'(pid_prod2);
      pid_inc   = signed'(pid_acc[ACC_W-1:FRAC_SHIFT]);
      pid_sum   = SUM_W'(drive_last_ff) + SUM_W'(pid_inc);
      if (pid_sum > DRIVE_ACC_MAX) begin
         pid_store = drive_acc_type'(DRIVE_ACC_MAX);
      end else if (pid_sum < DRIVE_ACC_MIN) begin
         pid_store = drive_acc_type'(DRIVE_ACC_MIN);
      end else begin
         pid_store = pid_sum[DRIVE_ACC_W-1:0];
      end
      limit_pos = signed'({9'b0, drive_limit_ff});

      drive_in             = '0;
      clipped_in           = 1'b0;
      error_last_in        = error_last_ff;
      error_before_last_in = error_before_last_ff;
      drive_last_in        = drive_last_ff;

      case (control_mode_ff)
         MODE_PASS: begin
            drive_in = reference_ff;
         end
         MODE_BANG_UNI: begin
            drive_in = (err > 0) ? bang_pos : '0;
         end
         MODE_BANG_BI: begin
            if (err > 0) begin
               drive_in = bang_pos;
            end else if (err < 0) begin
               drive_in = -bang_pos;
            end
         end
         MODE_BANG_HYST: begin
            drive_last_in = hyst_drive;
            if (hyst_drive > SAMPLE_MAX) begin
               drive_in   = sample_type'(SAMPLE_MAX);
               clipped_in = 1'b1;
            end else if (hyst_drive < SAMPLE_MIN) begin
               drive_in   = sample_type'(SAMPLE_MIN);
               clipped_in = 1'b1;
            end else begin
               drive_in = hyst_drive[SAMPLE_W-1:0];
            end
         end
         MODE_PROP: begin
            if (prop_q > SAMPLE_MAX) begin
               drive_in   = sample_type'(SAMPLE_MAX);
               clipped_in = 1'b1;
            end else if (prop_q < SAMPLE_MIN) begin
               drive_in   = sample_type'(SAMPLE_MIN);
               clipped_in = 1'b1;
            end else begin
               drive_in = prop_q[SAMPLE_W-1:0];
            end
         end
         MODE_PID: begin
            error_before_last_in = error_last_ff;
            error_last_in        = err;
            drive_last_in        = pid_store;
            // store the sum saturated only to the accumulator range, clip the outgoing drive
            if (pid_store > limit_pos) begin
               drive_in   = limit_pos[SAMPLE_W-1:0];
               clipped_in = 1'b1;
            end else if (pid_store < -limit_pos) begin
               drive_in   = -limit_pos[SAMPLE_W-1:0];
               clipped_in = 1'b1;
            end else begin
               drive_in = pid_store[SAMPLE_W-1:0];
            end
         end
         default: ;
      endcase
   end

   // --------------------------------------------------------------------
   // Registers
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         error_last_ff        <= '0;
         error_before_last_ff <= '0;
         drive_last_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            error_last_ff        <= error_last_in;
            error_before_last_ff <= error_before_last_in;
            drive_last_ff        <= drive_last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         reference_ff <= req_bus.reference;
         measured_ff  <= req_bus.measured;
      end
      if (advance) begin
         drive_ff   <= drive_in;
         clipped_ff <= clipped_in;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.drive   = drive_ff;
   assign rsp_bus.clipped = clipped_ff;

   // --------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------
   a_no_clip_simple_modes: assert property (@(posedge clock) disable iff (reset)
      advance && (control_mode_ff == MODE_PASS || control_mode_ff == MODE_BANG_UNI ||
                  control_mode_ff == MODE_BANG_BI)
      |=> !rsp_bus.clipped)
      else $error("clipped set in a mode that never clips");

   a_pid_within_limit: assert property (@(posedge clock) disable iff (reset)
      advance && control_mode_ff == MODE_PID
      |=> (rsp_bus.drive <= $signed({1'b0, $past(drive_limit_ff)})) &&
          (rsp_bus.drive >= -$signed({1'b0, $past(drive_limit_ff)})))
      else $error("PID drive outside the drive limit");

   a_pid_history_shift: assert property (@(posedge clock) disable iff (reset)
      advance && control_mode_ff == MODE_PID
      |=> error_before_last_ff == $past(error_last_ff))
      else $error("error history did not shift");

   a_history_held: assert property (@(posedge clock) disable iff (reset)
      advance && control_mode_ff != MODE_PID
      |=> $stable(error_last_ff) && $stable(error_before_last_ff))
      else $error("error history changed outside PID mode");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(reference_ff))
      else $error("pending sample lost before it moved on");

endmodule
